@@ design/stl_pkg.sv @@
// Shared types and constants for the script token lexer.
`timescale 1ns / 1ps

package stl_pkg;

  // Token length width and largest token limit.
  localparam int LEN_W     = 11;
  localparam int MAX_TOKEN = 1024;

  // Configuration port geometry: 64-bit registers at 8-byte strides.
  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_LIMIT   = 2'd0;
  localparam logic [1:0] REG_MASK_LO = 2'd1;
  localparam logic [1:0] REG_MASK_HI = 2'd2;

  // Register reset values.
  localparam logic [LEN_W-1:0]  LIMIT_RESET   = 11'd1024;
  localparam logic [DATA_W-1:0] MASK_LO_RESET = 64'd8935172180740669440;
  localparam logic [DATA_W-1:0] MASK_HI_RESET = 64'd4035225266123964416;

  // Characters with a fixed role in the scanner.
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Result queue between the scanner and the output stage.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // One result beat.
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
    logic       quoted;
    logic       trunc;
  } res_t;

  // One queue entry: the one or two results caused by one input byte.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  // Configuration as seen by the scanner.
  typedef struct packed {
    logic [LEN_W-1:0]  limit;
    logic [DATA_W-1:0] mask_lo;
    logic [DATA_W-1:0] mask_hi;
  } cfg_t;

endpackage

@@ design/stl_if.sv @@
// Valid/ready channel interfaces for text bytes and token beats.
`timescale 1ns / 1ps

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface stl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       last;
  logic       quoted;
  logic       truncated;

  modport source (output valid, output out_char, output has_char, output last,
                  output quoted, output truncated, input ready);
  modport sink (input valid, input out_char, input has_char, input last,
                input quoted, input truncated, output ready);
endinterface

@@ design/script_token_lexer_unit.sv @@
// Top level of the script token lexer: registers, scanner, queue and output stage.
`timescale 1ns / 1ps

// The lexer takes one text byte per cycle while the result queue is not full
// and sends tokens out one character per beat, with last set on the final
// beat of each token. The scanner state (mode, length and held character) is
// the only loop; the result queue (four entries) sits between the scanner and
// the output register, so the scanner keeps taking bytes while the output
// side is stalled, until the queue fills. A byte that ends a token and
// starts a punctuation token, or that fills a string, gives two beats, and
// the output register sends one beat per cycle while the receiver is ready.
// Configuration registers are at byte addresses 0 (token limit), 8
// (punctuation mask, codes 0 to 63) and 16 (punctuation mask, codes 64 to
// 127); they are to be written only while idle, which the block does not enforce.

module script_token_lexer_unit import stl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  stl_in_if.sink            in_ch,
  stl_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg;
  logic   push, pop, q_full, q_not_empty, wr_en;
  entry_t push_data, head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit   <= LIMIT_RESET;
      cfg.mask_lo <= MASK_LO_RESET;
      cfg.mask_hi <= MASK_HI_RESET;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_LIMIT:   cfg.limit   <= pwdata[LEN_W-1:0];
        REG_MASK_LO: cfg.mask_lo <= pwdata;
        REG_MASK_HI: cfg.mask_hi <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:3])
      REG_LIMIT:   prdata = DATA_W'(cfg.limit);
      REG_MASK_LO: prdata = cfg.mask_lo;
      REG_MASK_HI: prdata = cfg.mask_hi;
      default:     prdata = '0;
    endcase
  end

  stl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  stl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (push_data),
    .pop       (pop),
    .rd_data   (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  stl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (q_not_empty),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // The scanner never writes into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("result queue overflow");

  // A beat without a character can only be the end of an empty string.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.has_char) |-> (out_ch.quoted && out_ch.last))
    else $error("empty beat outside an empty quoted token");

  // A cut token is marked only on its final beat.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.truncated) |-> out_ch.last)
    else $error("truncated set on a beat that is not last");

  // Reset empties the output stage.
  assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

@@ design/stl_front.sv @@
// Scanner front end: takes text bytes, tracks the scan mode, forms results.
`timescale 1ns / 1ps

module stl_front import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  stl_in_if.sink     in_ch,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_data
);

  // Scan modes.
  localparam logic [2:0] M_WHITE = 3'd0;
  localparam logic [2:0] M_SLASH = 3'd1;
  localparam logic [2:0] M_LINE  = 3'd2;
  localparam logic [2:0] M_BLOCK = 3'd3;
  localparam logic [2:0] M_BSTAR = 3'd4;
  localparam logic [2:0] M_QUOTE = 3'd5;
  localparam logic [2:0] M_WORD  = 3'd6;

  function automatic res_t mk_res(input logic [7:0] ch, input logic has,
                                  input logic last, input logic quoted,
                                  input logic trunc);
    res_t r;
    r.ch     = has ? ch : 8'h00;
    r.has    = has;
    r.last   = last;
    r.quoted = quoted;
    r.trunc  = trunc;
    return r;
  endfunction

  logic [2:0]       mode, mode_next;
  logic [LEN_W-1:0] len, len_next;
  logic [7:0]       hc, hc_next;
  logic             hv, hv_next;

  logic [7:0]       b;
  logic             accept;
  logic [LEN_W-1:0] lim, cap, len_inc, wl;
  logic [7:0]       wc;
  logic             b_punct, slash_punct, b_white;
  logic             e0_v, e1_v, sp_v, do_start, word_go;
  res_t             e0, e1, sp;

  assign b            = in_ch.in_byte;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && !q_full;
  assign len_inc      = len + LEN_W'(1);
  assign b_white      = (b <= CH_SPACE);
  assign slash_punct  = cfg.mask_lo[CH_SLASH[5:0]];

  // Punctuation lookup: high bytes are never punctuation.
  assign b_punct = b[7] ? 1'b0 : (b[6] ? cfg.mask_hi[b[5:0]] : cfg.mask_lo[b[5:0]]);

  // Clamp the limit to its legal range; a token holds one less than the limit.
  always_comb begin
    lim = cfg.limit;
    if (lim < LEN_W'(2)) begin
      lim = LEN_W'(2);
    end
    if (lim > LEN_W'(MAX_TOKEN)) begin
      lim = LEN_W'(MAX_TOKEN);
    end
    cap = lim - LEN_W'(1);
  end

  // Next-state and result logic for one byte.
  always_comb begin
    mode_next = mode;
    len_next  = len;
    hc_next   = hc;
    hv_next   = hv;
    e0_v      = 1'b0;
    e0        = '0;
    e1_v      = 1'b0;
    e1        = '0;
    sp_v      = 1'b0;
    sp        = '0;
    do_start  = 1'b0;
    word_go   = 1'b0;
    wc        = hc;
    wl        = len;

    case (mode)
      M_SLASH: begin
        if (b == CH_SLASH) begin
          mode_next = M_LINE;
        end else if (b == CH_STAR) begin
          mode_next = M_BLOCK;
        end else if (slash_punct) begin
          e0_v     = 1'b1;
          e0       = mk_res(CH_SLASH, 1'b1, 1'b1, 1'b0, 1'b0);
          do_start = 1'b1;
        end else begin
          // The slash starts a word; the byte continues or ends it.
          word_go = 1'b1;
          wc      = CH_SLASH;
          wl      = LEN_W'(1);
        end
      end
      M_LINE: begin
        if (b == CH_END) begin
          mode_next = M_WHITE;
          len_next  = '0;
          hc_next   = '0;
          hv_next   = 1'b0;
        end else if (b == CH_NL) begin
          mode_next = M_WHITE;
        end
      end
      M_BLOCK: begin
        if (b == CH_END) begin
          mode_next = M_WHITE;
          len_next  = '0;
          hc_next   = '0;
          hv_next   = 1'b0;
        end else if (b == CH_STAR) begin
          mode_next = M_BSTAR;
        end
      end
      M_BSTAR: begin
        if (b == CH_END) begin
          mode_next = M_WHITE;
          len_next  = '0;
          hc_next   = '0;
          hv_next   = 1'b0;
        end else if (b == CH_SLASH) begin
          mode_next = M_WHITE;
        end else if (b != CH_STAR) begin
          mode_next = M_BLOCK;
        end
      end
      M_QUOTE: begin
        if (len >= cap) begin
          e0_v     = 1'b1;
          e0       = mk_res(hc, hv, 1'b1, 1'b1, 1'b1);
          do_start = 1'b1;
        end else if (b == CH_QUOTE || b == CH_END) begin
          e0_v      = 1'b1;
          e0        = mk_res(hc, hv, 1'b1, 1'b1, 1'b0);
          mode_next = M_WHITE;
          len_next  = '0;
          hc_next   = '0;
          hv_next   = 1'b0;
        end else begin
          if (hv) begin
            e0_v = 1'b1;
            e0   = mk_res(hc, 1'b1, 1'b0, 1'b1, 1'b0);
          end
          hc_next  = b;
          hv_next  = 1'b1;
          len_next = len_inc;
          // The string is full: close it here as cut.
          if (len_inc >= cap) begin
            e1_v      = 1'b1;
            e1        = mk_res(b, 1'b1, 1'b1, 1'b1, 1'b1);
            mode_next = M_WHITE;
            len_next  = '0;
            hc_next   = '0;
            hv_next   = 1'b0;
          end
        end
      end
      M_WORD: begin
        word_go = 1'b1;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // A word releases its held character once the next byte is known.
    if (word_go) begin
      if (b_white || b_punct) begin
        e0_v     = 1'b1;
        e0       = mk_res(wc, 1'b1, 1'b1, 1'b0, 1'b0);
        do_start = 1'b1;
      end else if (wl >= cap) begin
        e0_v     = 1'b1;
        e0       = mk_res(wc, 1'b1, 1'b1, 1'b0, 1'b1);
        do_start = 1'b1;
      end else begin
        e0_v      = 1'b1;
        e0        = mk_res(wc, 1'b1, 1'b0, 1'b0, 1'b0);
        mode_next = M_WORD;
        hc_next   = b;
        hv_next   = 1'b1;
        len_next  = wl + LEN_W'(1);
      end
    end

    // Fresh scan from the current byte.
    if (do_start) begin
      mode_next = M_WHITE;
      len_next  = '0;
      hc_next   = '0;
      hv_next   = 1'b0;
      if (!b_white) begin
        if (b == CH_SLASH) begin
          mode_next = M_SLASH;
        end else if (b == CH_QUOTE) begin
          mode_next = M_QUOTE;
        end else if (b_punct) begin
          sp_v = 1'b1;
          sp   = mk_res(b, 1'b1, 1'b1, 1'b0, 1'b0);
        end else begin
          mode_next = M_WORD;
          hc_next   = b;
          hv_next   = 1'b1;
          len_next  = LEN_W'(1);
        end
      end
    end
  end

  // Pack the results of this byte into one queue entry, in order.
  always_comb begin
    push          = accept && (e0_v || e1_v || sp_v);
    push_data.two = e0_v && (e1_v || sp_v);
    push_data.r0  = e0_v ? e0 : (e1_v ? e1 : sp);
    push_data.r1  = e1_v ? e1 : sp;
  end

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_WHITE;
      len  <= '0;
      hc   <= '0;
      hv   <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      len  <= len_next;
      hc   <= hc_next;
      hv   <= hv_next;
    end
  end

endmodule

@@ design/stl_queue.sv @@
// Small result queue between the scanner and the output stage.
`timescale 1ns / 1ps

module stl_queue import stl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_data,
  input  logic   pop,
  output entry_t rd_data,
  output logic   not_empty,
  output logic   full
);

  entry_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]     count;

  assign rd_data   = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (Q_PTR_W + 1)'(Q_DEPTH));

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_PTR_W + 1)'(1);
      end
    end
  end

endmodule

@@ design/stl_back.sv @@
// Output stage: splits queue entries into single token beats.
`timescale 1ns / 1ps

module stl_back import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       head_valid,
  output logic       pop,
  stl_out_if.source  out_ch
);

  logic out_valid, pend_valid, take;
  res_t out_res, pend;

  assign take = !out_valid || out_ch.ready;
  assign pop  = take && !pend_valid && head_valid;

  assign out_ch.valid     = out_valid;
  assign out_ch.out_char  = out_res.ch;
  assign out_ch.has_char  = out_res.has;
  assign out_ch.last      = out_res.last;
  assign out_ch.quoted    = out_res.quoted;
  assign out_ch.truncated = out_res.trunc;

  // Output register and the second result of a two-result entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (take) begin
      if (pend_valid) begin
        out_res    <= pend;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (head_valid) begin
        out_res    <= head.r0;
        out_valid  <= 1'b1;
        pend       <= head.r1;
        pend_valid <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
